[rtl/bcc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants for the button click classifier.
// ----------------------------------------------------------------------------
package bcc_pkg;

    localparam int TIMER_BITS = 16;
    localparam int CFG_W      = 16;
    localparam int CMP_W      = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam int CODE_W     = 3;
    localparam int COUNT_W    = 2;
    localparam int CFG_ADDR_W = 1;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 8;

    typedef logic [TIMER_BITS-1:0] timer_t;
    typedef logic [CFG_W-1:0]      cfg_word_t;
    typedef logic [CODE_W-1:0]     code_t;
    typedef logic [COUNT_W-1:0]    count_t;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_MULTI_CLICK = 1'b1;

    localparam cfg_word_t LONG_PRESS_RESET  = 16'd100;
    localparam cfg_word_t MULTI_CLICK_RESET = 16'd50;

    localparam timer_t TIMER_MAX = {TIMER_BITS{1'b1}};
    localparam count_t COUNT_MAX = {COUNT_W{1'b1}};

    localparam code_t EVENT_LONG_PRESS = 3'd4;

    localparam logic LEVEL_PRESSED  = 1'b0;
    localparam logic LEVEL_RELEASED = 1'b1;

    typedef struct packed {
        logic  valid;
        code_t code;
    } evt_t;

endpackage
`default_nettype wire

[rtl/button_click_classifier.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// button_click_classifier
// Classifies a sampled, active-low button level into single, double, triple
// click and long press events.
//
//   channel  dir  payload
//   s_*      in   tdata[0] button_level
//   m_*      out  tdata[2:0] event_code
//   cfg_*    in   index 0 long_press_ticks, 1 multi_click_ticks
//
// one sample per cycle while s_tready is high; m_* is driven from a register.
// the result register plus one skid entry hold results; s_tready drops only
// while the skid entry is full.
// synchronous active-low reset, no clearing pass.
// ----------------------------------------------------------------------------
module button_click_classifier (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_tvalid,
    output logic                             s_tready,
    input  wire [bcc_pkg::S_DATA_W-1:0]      s_tdata,   // [0] button_level
    output logic                             m_tvalid,
    input  wire                              m_tready,
    output logic [bcc_pkg::M_DATA_W-1:0]     m_tdata,   // [2:0] event_code
    input  wire                              cfg_we,
    input  wire [bcc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire [bcc_pkg::CFG_W-1:0]         cfg_wdata
);
    import bcc_pkg::*;

    evt_t evt;
    logic in_ready;
    logic step;

    assign s_tready = in_ready;
    assign step     = s_tvalid & in_ready;

    bcc_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (step),
        .button_level (s_tdata[0]),
        .cfg_we       (cfg_we),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .evt          (evt)
    );

    bcc_obuf u_obuf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .evt      (evt),
        .in_ready (in_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
`default_nettype wire

[rtl/bcc_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_core
// Config registers, edge/timer/click state and the per-sample classification.
// ----------------------------------------------------------------------------
module bcc_core (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              step,
    input  wire                              button_level,
    input  wire                              cfg_we,
    input  wire [bcc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire [bcc_pkg::CFG_W-1:0]         cfg_wdata,
    output bcc_pkg::evt_t                    evt
);
    import bcc_pkg::*;

    cfg_word_t long_press_reg;
    cfg_word_t multi_click_reg;
    logic      prev_level_reg,  prev_level_next;
    timer_t    since_press_reg, since_press_next;
    timer_t    since_rel_reg,   since_rel_next;
    count_t    count_reg,       count_next;

    logic      press_edge;
    logic      release_edge;
    timer_t    press_mid;
    timer_t    rel_mid;
    count_t    count_mid;
    logic      is_long;
    logic      timeout;

    always_comb begin
        press_edge   = (button_level == LEVEL_PRESSED) && (prev_level_reg == LEVEL_RELEASED);
        release_edge = (button_level == LEVEL_RELEASED) && (prev_level_reg == LEVEL_PRESSED);

        press_mid = press_edge   ? '0 : since_press_reg;
        rel_mid   = release_edge ? '0 : since_rel_reg;

        // click sequence update on a press
        count_mid = count_reg;
        if (press_edge) begin
            if ((since_rel_reg != TIMER_MAX) &&
                (CMP_W'(since_rel_reg) < CMP_W'(multi_click_reg))) begin
                count_mid = (count_reg == COUNT_MAX) ? COUNT_MAX : count_reg + 1'b1;
            end else begin
                count_mid = count_t'(1);
            end
        end

        is_long = release_edge &&
                  ((since_press_reg == TIMER_MAX) ||
                   (CMP_W'(since_press_reg) >= CMP_W'(long_press_reg)));

        evt.valid = 1'b0;
        evt.code  = EVENT_LONG_PRESS;
        if (is_long) begin
            evt.valid = 1'b1;
            count_mid = '0;
        end

        // window expired with clicks pending
        timeout = (count_mid != '0) && (button_level == LEVEL_RELEASED) &&
                  ((rel_mid == TIMER_MAX) || (CMP_W'(rel_mid) > CMP_W'(multi_click_reg)));
        count_next = count_mid;
        if (timeout) begin
            evt.valid  = 1'b1;
            evt.code   = CODE_W'(count_mid);
            count_next = '0;
        end

        evt.valid = evt.valid & step;

        prev_level_next  = button_level;
        since_press_next = (press_mid == TIMER_MAX) ? TIMER_MAX : press_mid + 1'b1;
        since_rel_next   = (rel_mid == TIMER_MAX) ? TIMER_MAX : rel_mid + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg  <= LONG_PRESS_RESET;
            multi_click_reg <= MULTI_CLICK_RESET;
            prev_level_reg  <= LEVEL_RELEASED;
            since_press_reg <= '0;
            since_rel_reg   <= TIMER_MAX;
            count_reg       <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_LONG_PRESS: begin
                        long_press_reg <= cfg_wdata;
                    end
                    REG_MULTI_CLICK: begin
                        multi_click_reg <= cfg_wdata;
                    end
                    default: begin
                    end
                endcase
            end
            if (step) begin
                prev_level_reg  <= prev_level_next;
                since_press_reg <= since_press_next;
                since_rel_reg   <= since_rel_next;
                count_reg       <= count_next;
            end
        end
    end

endmodule
`default_nettype wire

[rtl/bcc_obuf.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcc_obuf
// Result register with a skid stage so the input side keeps moving while a
// result waits on the output.
// ----------------------------------------------------------------------------
module bcc_obuf (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  bcc_pkg::evt_t                evt,
    output logic                         in_ready,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [bcc_pkg::M_DATA_W-1:0] m_tdata
);
    import bcc_pkg::*;

    logic  out_valid_reg,  out_valid_next;
    code_t out_code_reg,   out_code_next;
    logic  skid_valid_reg, skid_valid_next;
    code_t skid_code_reg,  skid_code_next;
    logic  out_take;

    always_comb begin
        out_take        = out_valid_reg & m_tready;
        out_valid_next  = out_valid_reg;
        out_code_next   = out_code_reg;
        skid_valid_next = skid_valid_reg;
        skid_code_next  = skid_code_reg;
        if (skid_valid_reg) begin
            if (out_take) begin
                out_code_next   = skid_code_reg;
                skid_valid_next = 1'b0;
            end
        end else if (evt.valid) begin
            if (!out_valid_reg || out_take) begin
                out_valid_next = 1'b1;
                out_code_next  = evt.code;
            end else begin
                skid_valid_next = 1'b1;
                skid_code_next  = evt.code;
            end
        end else if (out_take) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_code_reg  <= out_code_next;
        skid_code_reg <= skid_code_next;
    end

    assign in_ready = ~skid_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DATA_W'(out_code_reg);

endmodule
`default_nettype wire
